// ===== design/lru_key_value_cache_top_defines.svh =====
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Concurrent assertion shorthands, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define LKV_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define LKV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LKV_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define LKV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== design/lkv_cache_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Field widths, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkv_cache_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Operation codes
   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_STORE  = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch transaction and key match
      logic exec;      // update entries, access value RAM
      logic load;      // load response register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;  // response register can take a new result
   } status_type;

endpackage

`default_nettype wire

// ===== design/lkv_cache_intf.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache channel interfaces
// Valid/ready channels for requests, responses and the capacity register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lkv_cache_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic signed [lkv_cache_pkg::KEY_W-1:0] key;
   logic signed [lkv_cache_pkg::VAL_W-1:0] value;

   modport source (output valid, output kind, output key, output value, input ready);
   modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface lkv_cache_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 hit;
   logic signed [lkv_cache_pkg::VAL_W-1:0] read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lkv_cache_csr_if;
   logic                             valid;
   logic                             ready;
   logic [lkv_cache_pkg::CAP_W-1:0]  capacity;

   modport source (output valid, output capacity, input ready);
   modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// ===== design/lru_key_value_cache_top.sv =====
// Sequence: a request is captured, the execute state updates the entries and
// accesses the value RAM, and the done state loads the response register once it
// is free. No new request is taken until that load; the value RAM read is registered.
// The response register frees the input while a result waits to be taken.
// Reset: synchronous; clears valid bits, ranks, occupancy and sets capacity
// to 16. No clearing pass; the block accepts requests right after reset.
// ----------------------------------------------------------------------------
// LRU key-value cache top level
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_key_value_cache_top_defines.svh"

module lru_key_value_cache_top #(
   parameter int ENTRIES = 16
) (
   input wire logic       clock,
   input wire logic       reset,
   lkv_cache_req_if.sink  req_if,
   lkv_cache_rsp_if.source rsp_if,
   lkv_cache_csr_if.sink  csr_if
);

   lkv_cache_pkg::cmd_type    cmd;
   lkv_cache_pkg::status_type status;
   logic                      req_ready;

   // Capacity writes are always taken
   assign csr_if.ready = 1'b1;
   assign req_if.ready = req_ready;

   lkv_cache_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lkv_cache_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_if.kind),
      .req_key        (req_if.key),
      .req_value      (req_if.value),
      .csr_we         (csr_if.valid && csr_if.ready),
      .csr_capacity   (csr_if.capacity),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_hit        (rsp_if.hit),
      .rsp_read_value (rsp_if.read_value)
   );

   // Checks
   `LKV_ASSERT_NEXT(a_busy_after_accept, clock, reset, cmd.capture, !req_ready && cmd.exec, "request accepted but execute did not follow")
   `LKV_ASSERT_IMPLY(a_no_accept_in_exec, clock, reset, cmd.exec, !req_ready, "request ready while executing")
   `LKV_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load, rsp_if.valid, "response load did not raise valid")

endmodule

`default_nettype wire

// ===== design/lkv_cache_ram.sv =====
// ----------------------------------------------------------------------------
// LKV cache generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkv_cache_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]          wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output      logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/lkv_cache_ctrl.sv =====
// ----------------------------------------------------------------------------
// LKV cache controller
// Sequences each transaction through capture, execute and response load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkv_cache_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire lkv_cache_pkg::status_type status,
   output      lkv_cache_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.exec    = (state_ff == ST_EXEC);
   assign cmd.load    = (state_ff == ST_DONE) && status.out_free;

   // Advance through the transaction
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/lkv_cache_dp.sv =====
// ----------------------------------------------------------------------------
// LKV cache datapath
// Key match, recency ranks, occupancy, capacity and the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkv_cache_dp #(
   parameter int ENTRIES = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire lkv_cache_pkg::cmd_type                cmd,
   output      lkv_cache_pkg::status_type             status,
   input  wire logic                                  req_kind,
   input  wire logic signed [lkv_cache_pkg::KEY_W-1:0] req_key,
   input  wire logic signed [lkv_cache_pkg::VAL_W-1:0] req_value,
   input  wire logic                                  csr_we,
   input  wire logic [lkv_cache_pkg::CAP_W-1:0]       csr_capacity,
   input  wire logic                                  rsp_ready,
   output      logic                                  rsp_valid,
   output      logic                                  rsp_hit,
   output      logic signed [lkv_cache_pkg::VAL_W-1:0] rsp_read_value
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int OCC_W  = $clog2(ENTRIES + 1);

   // Entry state
   logic [ENTRIES-1:0]                      valid_ff, valid_in;
   logic [RANK_W-1:0]                       rank_ff [ENTRIES];
   logic [RANK_W-1:0]                       rank_in [ENTRIES];
   logic signed [lkv_cache_pkg::KEY_W-1:0]  keys_ff [ENTRIES];
   logic [OCC_W-1:0]                        occ_ff, occ_in;
   logic [lkv_cache_pkg::CAP_W-1:0]         cap_ff;

   // Captured transaction
   logic                                    kind_ff;
   logic signed [lkv_cache_pkg::KEY_W-1:0]  key_ff;
   logic signed [lkv_cache_pkg::VAL_W-1:0]  value_ff;
   logic [ENTRIES-1:0]                      match_ff, match_in;
   logic                                    hit_ff;

   // Response register
   logic                                    rsp_valid_ff;
   logic                                    rsp_hit_ff;
   logic signed [lkv_cache_pkg::VAL_W-1:0]  rsp_value_ff;

   logic [IDX_W-1:0]                        match_idx;
   logic [RANK_W-1:0]                       match_rank;
   logic [OCC_W-1:0]                        cap_eff;
   logic                                    full;
   logic                                    evict;
   logic [ENTRIES-1:0]                      victim;
   logic [ENTRIES-1:0]                      free_vec;
   logic [IDX_W-1:0]                        slot_idx;
   logic [ENTRIES-1:0]                      slot_vec;
   logic                                    is_store;
   logic                                    ram_we;
   logic                                    ram_re;
   logic [IDX_W-1:0]                        ram_waddr;
   logic [lkv_cache_pkg::VAL_W-1:0]         ram_rdata;

   // Compare the incoming key against every valid entry
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (keys_ff[i] == req_key);
      end
   end

   // Encode the one-hot match and fetch its rank
   always_comb begin
      match_idx  = '0;
      match_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_ff[i]) begin
            match_idx  = match_idx | IDX_W'(i);
            match_rank = match_rank | rank_ff[i];
         end
      end
   end

   // Clamp capacity into 1..ENTRIES
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = OCC_W'(1);
      end else if (32'(cap_ff) > 32'(ENTRIES)) begin
         cap_eff = OCC_W'(ENTRIES);
      end else begin
         cap_eff = OCC_W'(cap_ff);
      end
   end

   assign is_store = (kind_ff == lkv_cache_pkg::KIND_STORE);
   assign full     = (occ_ff >= cap_eff);
   assign evict    = is_store && !hit_ff && full;

   // Least recent entry holds the highest rank, occupancy minus one
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         victim[i] = valid_ff[i] && (rank_ff[i] == RANK_W'(occ_ff - 1'b1));
      end
   end

   assign free_vec = ~valid_ff | (evict ? victim : '0);

   // Pick the lowest free slot
   always_comb begin
      slot_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            slot_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         slot_vec[i] = (slot_idx == IDX_W'(i));
      end
   end

   // Next entry state for hits, inserts and evictions
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (cmd.exec) begin
         if (hit_ff) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && (rank_ff[i] < match_rank)) begin
                  rank_in[i] = RANK_W'(rank_ff[i] + 1'b1);
               end
               if (match_ff[i]) begin
                  rank_in[i] = '0;
               end
            end
         end else if (is_store) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && !(evict && victim[i])) begin
                  rank_in[i] = RANK_W'(rank_ff[i] + 1'b1);
               end
               if (evict && victim[i]) begin
                  valid_in[i] = 1'b0;
                  rank_in[i]  = '0;
               end
               if (slot_vec[i]) begin
                  valid_in[i] = 1'b1;
                  rank_in[i]  = '0;
               end
            end
            occ_in = evict ? occ_ff : OCC_W'(occ_ff + 1'b1);
         end
      end
   end

   // Entry control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // Write the key of a newly inserted entry
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (cmd.exec && is_store && !hit_ff && slot_vec[i]) begin
            keys_ff[i] <= key_ff;
         end
      end
   end

   // Capacity register, taken only while empty
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkv_cache_pkg::CAP_RESET;
      end else if (csr_we && (occ_ff == '0)) begin
         cap_ff <= csr_capacity;
      end
   end

   // Hold the transaction and its match
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         key_ff   <= req_key;
         value_ff <= req_value;
         match_ff <= match_in;
         hit_ff   <= |match_in;
      end
   end

   // Value store
   assign ram_we    = cmd.exec && is_store;
   assign ram_re    = cmd.exec && !is_store && hit_ff;
   assign ram_waddr = hit_ff ? match_idx : slot_idx;

   lkv_cache_ram #(
      .WIDTH (lkv_cache_pkg::VAL_W),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (value_ff),
      .rd_en   (ram_re),
      .rd_addr (match_idx),
      .rd_data (ram_rdata)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_hit_ff   <= hit_ff;
         rsp_value_ff <= (!is_store && hit_ff) ? ram_rdata : '0;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_value_ff;

endmodule

`default_nettype wire

// ===== tb/lkv_cache_checker.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache response checker
// Watches the request, response and capacity channels, keeps its own copy of
// the cache contents and recency order, and compares every response with
// the result it predicts for the matching request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkv_cache_checker #(
   parameter int ENTRIES = 16
) (
   input  logic            clock,
   input  logic            reset,
   lkv_cache_req_if        req_if,
   lkv_cache_rsp_if        rsp_if,
   lkv_cache_csr_if        csr_if,
   output int              error_count,
   output int              pending_count,
   output int              response_count,
   output int              hit_count,
   output int              eviction_count,
   output int              capacity_now
);
   import lkv_cache_pkg::*;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] read_value;
   } cache_rsp_type;

   // Responses predicted for accepted requests, oldest first
   cache_rsp_type    expected_responses[$];

   // Shadow copy of the cache lines; age 0 is the most recent
   logic [KEY_W-1:0] line_key   [ENTRIES];
   logic [VAL_W-1:0] line_value [ENTRIES];
   bit               line_valid [ENTRIES];
   int unsigned      line_age   [ENTRIES];
   int unsigned      line_count;
   logic [CAP_W-1:0] capacity_reg;

   int errors;
   int responses;
   int hits;
   int evictions;

   // Clamp the register to 1..ENTRIES
   function automatic int unsigned capacity_limit();
      int unsigned c;
      c = capacity_reg;
      if (c < 1) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
   endfunction

   // Make a line the most recent; lines younger than it age by one
   function automatic void promote_line(int idx);
      int unsigned old_age;
      int i;
      old_age = line_age[idx];
      for (i = 0; i < ENTRIES; i++) begin
         if (line_valid[i] && line_age[i] < old_age) line_age[i]++;
      end
      line_age[idx] = 0;
   endfunction

   // Drop the oldest valid line
   function automatic void drop_oldest_line();
      int victim;
      int i;
      victim = -1;
      for (i = 0; i < ENTRIES; i++) begin
         if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim])) victim = i;
      end
      if (victim >= 0) begin
         line_valid[victim] = 1'b0;
         line_age[victim] = 0;
         if (line_count > 0) line_count--;
         evictions++;
      end
   endfunction

   // Place a new key in the lowest free line as the most recent
   function automatic void fill_free_line(logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
      int slot;
      int i;
      slot = -1;
      for (i = 0; i < ENTRIES; i++) begin
         if (!line_valid[i] && slot < 0) slot = i;
      end
      if (slot < 0) return;
      for (i = 0; i < ENTRIES; i++) begin
         if (line_valid[i]) line_age[i]++;
      end
      line_key[slot]   = key;
      line_value[slot] = value;
      line_valid[slot] = 1'b1;
      line_age[slot]   = 0;
      line_count++;
   endfunction

   // Apply one request to the shadow cache and return its response
   function automatic cache_rsp_type predict_access(logic kind, logic [KEY_W-1:0] key,
                                                    logic [VAL_W-1:0] value);
      cache_rsp_type rsp;
      int found;
      int i;
      found = -1;
      for (i = 0; i < ENTRIES; i++) begin
         if (found < 0 && line_valid[i] && line_key[i] === key) found = i;
      end
      rsp.hit = (found >= 0);
      rsp.read_value = '0;
      if (found >= 0) hits++;
      if (kind == KIND_LOOKUP) begin
         if (found >= 0) begin
            rsp.read_value = line_value[found];
            promote_line(found);
         end
      end else if (found >= 0) begin
         line_value[found] = value;
         promote_line(found);
      end else begin
         if (line_count >= capacity_limit()) drop_oldest_line();
         fill_free_line(key, value);
      end
      return rsp;
   endfunction

   // Count a wrong field; detail only for the first few
   function automatic void flag_field(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (errors < 10)
         $display("ERROR: response %0d field %s: expected 0x%08h, got 0x%08h",
                  responses, field, want, got);
      errors++;
   endfunction

   // Track configuration, predict on each request, compare on each response
   always @(posedge clock) begin
      cache_rsp_type want;
      int i;
      if (reset) begin
         for (i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_age[i]   = 0;
         end
         line_count   = 0;
         capacity_reg = CAP_RESET;
         expected_responses.delete();
      end else begin
         // Capacity changes only while the cache is empty
         if (csr_if.valid && csr_if.ready && line_count == 0) capacity_reg = csr_if.capacity;
         if (req_if.valid && req_if.ready)
            expected_responses.push_back(predict_access(req_if.kind, req_if.key, req_if.value));
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_responses.size() == 0) begin
               if (errors < 10)
                  $display("ERROR: response %0d arrived with no request outstanding: hit %b value 0x%08h",
                           responses, rsp_if.hit, rsp_if.read_value);
               errors++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_if.hit !== want.hit) flag_field("hit", want.hit, rsp_if.hit);
               if (rsp_if.read_value !== want.read_value)
                  flag_field("read_value", want.read_value, rsp_if.read_value);
            end
            responses++;
         end
      end
      error_count    <= errors;
      pending_count  <= expected_responses.size();
      response_count <= responses;
      hit_count      <= hits;
      eviction_count <= evictions;
      capacity_now   <= capacity_limit();
   end

   initial begin
      errors    = 0;
      responses = 0;
      hits      = 0;
      evictions = 0;
   end

endmodule

// ===== tb/lru_key_value_cache_top_tb.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives lookups and stores in random bursts against a stalling receiver,
// writes the capacity register while empty and while full, and takes the
// verdict from the response checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_key_value_cache_top_tb;
   import lkv_cache_pkg::*;

   localparam int ENTRIES        = 16;
   localparam int CLK_HALF       = 4;
   localparam int RESET_CYCLES   = 12;
   localparam int NUM_PHASES     = 6;
   localparam int PHASE_ITEMS    = 270;
   localparam int PRESSURE_ITEMS = 40;
   localparam int LONG_HOLD      = 200;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Free-running clock
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   lkv_cache_req_if req_if ();
   lkv_cache_rsp_if rsp_if ();
   lkv_cache_csr_if csr_if ();

   lru_key_value_cache_top #(
      .ENTRIES (ENTRIES)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   int mismatches;
   int pending;
   int responses;
   int hits;
   int evictions;
   int capacity_eff;

   lkv_cache_checker #(
      .ENTRIES (ENTRIES)
   ) u_lru_check (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_if         (csr_if),
      .error_count    (mismatches),
      .pending_count  (pending),
      .response_count (responses),
      .hit_count      (hits),
      .eviction_count (evictions),
      .capacity_now   (capacity_eff)
   );

   int requests_sent = 0;
   int stores_sent   = 0;
   int csr_writes    = 0;
   int hold_requests = 0;
   int holds_done    = 0;
   int burst_left    = 0;
   int idle_cycles   = 0;

   logic [KEY_W-1:0] key_pool [32];
   int               pool_size;

   // Offer one request and hold it until accepted
   task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value);
      req_if.valid <= 1'b1;
      req_if.kind  <= kind;
      req_if.key   <= key;
      req_if.value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      requests_sent++;
      if (kind == KIND_STORE) stores_sent++;
   endtask

   // Drop valid for a number of cycles
   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_if.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Send in bursts with random gaps between them
   task automatic paced_request(input logic kind, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
      if (burst_left == 0) begin
         if ($urandom_range(0, 9) == 0) pause_sender($urandom_range(8, 20));
         else pause_sender($urandom_range(0, 5));
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      send_request(kind, key, value);
   endtask

   // Stop sending and wait until every response has come back
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One capacity register write, then valid is dropped before returning
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_if.valid    <= 1'b1;
      csr_if.capacity <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      csr_writes++;
      @(posedge clock);
   endtask

   // Receiver: random stall modes, plus a long hold-off on request
   initial begin
      stall_mode_type mode;
      int             mode_left;
      int             phase_cnt;
      mode      = STALL_NONE;
      mode_left = 0;
      phase_cnt = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            phase_cnt++;
            case (mode)
               STALL_NONE:     rsp_if.ready <= 1'b1;
               STALL_LIGHT:    rsp_if.ready <= ($urandom_range(0, 3) != 0);
               STALL_HEAVY:    rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default:        rsp_if.ready <= (phase_cnt % 3 != 0);
            endcase
         end
      end
   end

   // Watchdog: end the run if no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("ERROR: no transaction for %0d cycles, %0d responses outstanding",
                  WATCHDOG_LIMIT, pending);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      logic [CAP_W-1:0] cap_value;
      logic             kind;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      int               fill_keys;
      int               i;
      int               phase;
      int               n;

      req_if.valid    <= 1'b0;
      req_if.kind     <= KIND_LOOKUP;
      req_if.key      <= '0;
      req_if.value    <= '0;
      csr_if.valid    <= 1'b0;
      csr_if.capacity <= '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // While empty every write lands: both out-of-range ends, then the run value
      write_capacity(5'd31);
      write_capacity(5'd0);
      case ($urandom_range(0, 5))
         0:       cap_value = 5'd0;
         1:       cap_value = 5'd1;
         2:       cap_value = 5'd16;
         3:       cap_value = 5'd31;
         default: cap_value = 5'($urandom_range(2, 15));
      endcase
      write_capacity(cap_value);

      // Directed: lookup on empty cache, extreme keys and values, update in place
      send_request(KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(KIND_STORE,  32'h8000_0000, 32'h7FFF_FFFF);
      send_request(KIND_STORE,  32'h7FFF_FFFF, 32'h8000_0000);
      send_request(KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000);
      send_request(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(KIND_STORE,  32'h7FFF_FFFF, 32'h0000_0000);
      send_request(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h1234_5678);
      send_request(KIND_STORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);

      // Directed: overfill to force evictions, then hit and miss on both ends
      fill_keys = capacity_eff + 1;
      for (i = 0; i < fill_keys; i++)
         send_request(KIND_STORE, 32'h0000_0100 + i, ~(32'h0000_0100 + i));
      send_request(KIND_LOOKUP, 32'h0000_0100, 32'h0000_0000);
      send_request(KIND_LOOKUP, 32'h0000_0100 + fill_keys - 1, 32'h0000_0000);
      send_request(KIND_STORE,  32'h0000_0100 + fill_keys - 1, 32'h5A5A_A5A5);

      // Cache is no longer empty, so this write must be ignored
      wait_idle();
      write_capacity(5'd0);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         // Fresh working set slightly larger than the capacity
         pool_size = capacity_eff + $urandom_range(1, 4);
         for (i = 0; i < pool_size; i++) key_pool[i] = $urandom;
         case (phase % 4)
            0:       key_pool[0] = 32'h8000_0000;
            1:       key_pool[0] = 32'h7FFF_FFFF;
            2:       key_pool[0] = 32'hFFFF_FFFF;
            default: key_pool[0] = 32'h0000_0000;
         endcase

         // Long receiver hold-off while requests keep coming back to back
         n = 0;
         if (phase == 1) begin
            hold_requests <= hold_requests + 1;
            n = PRESSURE_ITEMS;
         end

         for (i = 0; i < PHASE_ITEMS; i++) begin
            kind = ($urandom_range(0, 1) != 0) ? KIND_STORE : KIND_LOOKUP;
            if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, pool_size - 1)];
            else key = $urandom;
            if ($urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 3))
                  0:       value = 32'h0000_0000;
                  1:       value = 32'hFFFF_FFFF;
                  2:       value = 32'h8000_0000;
                  default: value = 32'h7FFF_FFFF;
               endcase
            end else begin
               value = $urandom;
            end
            if (i < n) send_request(kind, key, value);
            else paced_request(kind, key, value);
            // Mid-phase pause until everything has drained
            if (phase == 3 && i == PHASE_ITEMS / 2) wait_idle();
         end

         // Between phases: drain, then a write the non-empty cache must ignore
         wait_idle();
         case (phase)
            0:       write_capacity(5'd31);
            1:       write_capacity(5'd1);
            2:       write_capacity(5'd16);
            3:       write_capacity(5'd0);
            default: write_capacity(5'($urandom_range(0, 31)));
         endcase
      end

      // Drain and let the pipeline settle
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d requests (%0d stores), %0d responses, %0d hits, %0d evictions",
               requests_sent, stores_sent, responses, hits, evictions);
      $display("Summary: %0d capacity writes, effective capacity %0d, %0d long receiver hold-off(s)",
               csr_writes, capacity_eff, holds_done);
      if (pending != 0)
         $display("ERROR: %0d expected responses never arrived", pending);
      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== lru_key_value_cache_top.f =====
+incdir+design
design/lkv_cache_pkg.sv
design/lkv_cache_intf.sv
design/lkv_cache_ram.sv
design/lkv_cache_ctrl.sv
design/lkv_cache_dp.sv
design/lru_key_value_cache_top.sv
tb/lkv_cache_checker.sv
tb/lru_key_value_cache_top_tb.sv
